// File: src/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg: shared types, tables and GF(2^8) helpers for the AES-128 cipher.
// Holds the item structs, the forward S-box and the MixColumns arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  localparam int NUM_ROUNDS = 10;

  // Configuration register indexes.
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  localparam logic [7:0] GF_POLY  = 8'h1b;
  localparam logic [7:0] RCON_ONE = 8'h01;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } plain_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_t;

  // What moves from one round cell to the next.
  typedef struct packed {
    logic [127:0] state;
    logic [127:0] rkey;
    logic [7:0]   rcon;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] mul2(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
  endfunction

  // One MixColumns column; byte for row 0 sits in the top bits.
  function automatic logic [31:0] mix_column(input logic [31:0] col);
    logic [7:0] a0, a1, a2, a3;
    a0 = col[31:24];
    a1 = col[23:16];
    a2 = col[15:8];
    a3 = col[7:0];
    return {mul2(a0) ^ mul2(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ mul2(a1) ^ mul2(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ mul2(a2) ^ mul2(a3) ^ a3,
            mul2(a0) ^ a0 ^ a1 ^ a2 ^ mul2(a3)};
  endfunction

endpackage

`default_nettype wire

// File: src/aes128_block_encrypt.sv
// ----------------------------------------------------------------------------
// aes128_block_encrypt: pipelined AES-128 forward cipher.
// A load stage followed by a chain of ten round cells, one round per cell.
// ----------------------------------------------------------------------------
// Usage:
//   The key is written through wr_en / wr_index / wr_data: index 0 holds key
//   bytes 0..7, index 1 key bytes 8..15. Write it only while no item is in
//   flight; every item in the pipe carries its own round key along.
//   Plaintext items enter on plain_valid / plain_ready / plain and ciphertext
//   items leave on cipher_valid / cipher_ready / cipher, in order.
//   With the receiver taking results at once, an accepted item passes the load
//   stage (initial AddRoundKey), written at the accepting edge, and then each
//   round cell in turn before cipher_valid rises. Throughput is one item per
//   cycle while the receiver does not stall; each cell holds one block and
//   passes it on every cycle it is allowed to.
//   When the receiver stalls, the last cell holds its result and every full
//   cell behind it stops in the same cycle through the ready chain; empty
//   cells keep filling, so new items are taken until the whole chain is full.
//   A synchronous reset empties the chain and clears the key to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_block_encrypt (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [63:0]      wr_data,
  input  logic             plain_valid,
  output logic             plain_ready,
  input  aes_pkg::plain_t  plain,
  output logic             cipher_valid,
  input  logic             cipher_ready,
  output aes_pkg::cipher_t cipher
);
  import aes_pkg::*;

  logic [63:0] key_high;
  logic [63:0] key_low;

  logic   valid [NUM_ROUNDS + 1];
  logic   ready [NUM_ROUNDS + 1];
  stage_t stage [NUM_ROUNDS + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_KEY_HIGH: key_high <= wr_data;
        REG_KEY_LOW:  key_low  <= wr_data;
        default: ;
      endcase
    end
  end

  // Load stage: initial AddRoundKey, with the key itself as round key zero.
  assign ready[0]    = !valid[0] || ready[1];
  assign plain_ready = ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (ready[0]) begin
      valid[0] <= plain_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready[0] && plain_valid) begin
      stage[0].state <= {plain.plain_high, plain.plain_low} ^ {key_high, key_low};
      stage[0].rkey  <= {key_high, key_low};
      stage[0].rcon  <= RCON_ONE;
    end
  end

  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
    logic down_ready;
    if (r == NUM_ROUNDS) begin : g_last
      assign down_ready = cipher_ready;
    end else begin : g_mid
      assign down_ready = ready[r + 1];
    end

    aes_round_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .last_round (r == NUM_ROUNDS),
      .in_valid   (valid[r - 1]),
      .in_ready   (ready[r]),
      .in_stage   (stage[r - 1]),
      .out_valid  (valid[r]),
      .out_ready  (down_ready),
      .out_stage  (stage[r])
    );
  end

  assign cipher_valid       = valid[NUM_ROUNDS];
  assign cipher.cipher_high = stage[NUM_ROUNDS].state[127:64];
  assign cipher.cipher_low  = stage[NUM_ROUNDS].state[63:0];

endmodule

`default_nettype wire

// File: src/aes_round_cell.sv
// ----------------------------------------------------------------------------
// aes_round_cell: one AES round with its own round key expansion step.
// Registers the new state, round key and Rcon and hands them to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            last_round,
  input  logic            in_valid,
  output logic            in_ready,
  input  aes_pkg::stage_t in_stage,
  output logic            out_valid,
  input  logic            out_ready,
  output aes_pkg::stage_t out_stage
);
  import aes_pkg::*;

  logic [31:0]  temp;
  logic [31:0]  w0, w1, w2, w3;
  logic [127:0] shifted;
  logic [127:0] mixed;
  stage_t       stage_next;

  // Key schedule step: this round's key is expanded from the previous round key.
  always_comb begin
    temp = {SBOX[in_stage.rkey[23:16]] ^ in_stage.rcon,
            SBOX[in_stage.rkey[15:8]],
            SBOX[in_stage.rkey[7:0]],
            SBOX[in_stage.rkey[31:24]]};
    w0 = in_stage.rkey[127:96] ^ temp;
    w1 = in_stage.rkey[95:64] ^ w0;
    w2 = in_stage.rkey[63:32] ^ w1;
    w3 = in_stage.rkey[31:0] ^ w2;
  end

  // SubBytes and ShiftRows: row r of column c comes from column c + r.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[127 - 8 * (4 * c + r) -: 8] =
          SBOX[in_stage.state[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mixed[127 - 32 * c -: 32] = mix_column(shifted[127 - 32 * c -: 32]);
    end
  end

  always_comb begin
    stage_next.rkey  = {w0, w1, w2, w3};
    stage_next.state = (last_round ? shifted : mixed) ^ {w0, w1, w2, w3};
    stage_next.rcon  = mul2(in_stage.rcon);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_stage <= stage_next;
    end
  end

endmodule

`default_nettype wire

// File: src/aes_checker.sv
// ----------------------------------------------------------------------------
// aes_checker: port-level checks for the AES-128 cipher pipeline.
// Watches reset, back-pressure and the ready chain; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_checker (
  input logic             clk,
  input logic             rst,
  input logic             plain_ready,
  input logic             cipher_valid,
  input logic             cipher_ready,
  input aes_pkg::cipher_t cipher
);

  // Reset empties every cell.
  a_reset_empty: assert property (@(posedge clk) rst |=> !cipher_valid)
    else $error("cipher_valid high after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> plain_ready)
    else $error("plain_ready low after reset");

  // With the output free to move, every cell can advance, so plain_ready is high.
  a_chain_ready: assert property (@(posedge clk) disable iff (rst)
    (!cipher_valid || cipher_ready) |-> plain_ready)
    else $error("input stalled while the output stage can advance");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (cipher_valid && !cipher_ready) |=> (cipher_valid && $stable(cipher)))
    else $error("stalled result item changed or dropped");

endmodule

bind aes128_block_encrypt aes_checker u_aes_checker (
  .clk          (clk),
  .rst          (rst),
  .plain_ready  (plain_ready),
  .cipher_valid (cipher_valid),
  .cipher_ready (cipher_ready),
  .cipher       (cipher)
);

`default_nettype wire

// File: tb/aes128_block_encrypt_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_encrypt_test: self-checking testbench for the AES-128 cipher.
// Plaintext items flow from a queue through a valid/ready driver with random
// gaps, while the receiver stalls at random. Each accepted item is encrypted
// by a behavioral AES-128 under the current key and compared field by field
// with the ciphertext leaving the block, in order.
// ----------------------------------------------------------------------------

module aes128_block_encrypt_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic wr_index = aes_pkg::REG_KEY_HIGH;
  logic [63:0] wr_data = '0;
  logic plain_valid = 1'b0;
  logic plain_ready;
  aes_pkg::plain_t plain = '0;
  logic cipher_valid;
  logic cipher_ready = 1'b0;
  aes_pkg::cipher_t cipher;

  aes128_block_encrypt u_dut (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .plain_valid  (plain_valid),
    .plain_ready  (plain_ready),
    .plain        (plain),
    .cipher_valid (cipher_valid),
    .cipher_ready (cipher_ready),
    .cipher       (cipher)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Key as the block should hold it, and the forward S-box built from scratch.
  logic [63:0] key_high_cfg = '0;
  logic [63:0] key_low_cfg = '0;
  logic [7:0] sub_table [256];

  aes_pkg::plain_t pending_blocks [$];
  aes_pkg::cipher_t expected_cipher [$];
  int blocks_issued = 0;
  int blocks_returned = 0;
  int error_count = 0;
  int cycle_count = 0;

  // One-in-N odds of starting an idle burst; zero turns idling off.
  int gap_odds = 0;
  int stall_odds = 0;
  int gap_left = 0;
  int stall_left = 0;
  logic plain_fire = 1'b0;

  function automatic logic [7:0] times_two(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= x;
      x = times_two(x);
    end
    return acc;
  endfunction

  // S-box entry: multiplicative inverse (a^254) followed by the affine map.
  function automatic void build_sub_table();
    logic [7:0] inv;
    for (int v = 0; v < 256; v++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gf_mul(inv, v[7:0]);
      sub_table[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                     {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    end
  endfunction

  function automatic aes_pkg::cipher_t aes_encrypt(input logic [63:0] k_hi,
                                                   input logic [63:0] k_lo,
                                                   input logic [127:0] blk);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] sh [16];
    logic [7:0] t0, t1, t2, t3, first, rcon;
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] key;
    logic [127:0] res;
    key = {k_hi, k_lo};
    for (int n = 0; n < 16; n++) begin
      rk[n] = key[127 - 8 * n -: 8];
      st[n] = blk[127 - 8 * n -: 8] ^ rk[n];
    end
    rcon = 8'h01;
    for (int pos = 16; pos < 176; pos += 4) begin
      t0 = rk[pos - 4];
      t1 = rk[pos - 3];
      t2 = rk[pos - 2];
      t3 = rk[pos - 1];
      if (pos % 16 == 0) begin
        first = t0;
        t0 = sub_table[t1] ^ rcon;
        t1 = sub_table[t2];
        t2 = sub_table[t3];
        t3 = sub_table[first];
        rcon = times_two(rcon);
      end
      rk[pos] = rk[pos - 16] ^ t0;
      rk[pos + 1] = rk[pos - 15] ^ t1;
      rk[pos + 2] = rk[pos - 14] ^ t2;
      rk[pos + 3] = rk[pos - 13] ^ t3;
    end
    for (int r = 1; r <= 10; r++) begin
      // Row n of the state rotates left by n columns on its way through.
      for (int c = 0; c < 4; c++)
        for (int row = 0; row < 4; row++)
          sh[c * 4 + row] = sub_table[st[((c + row) % 4) * 4 + row]];
      for (int c = 0; c < 4; c++) begin
        a0 = sh[c * 4];
        a1 = sh[c * 4 + 1];
        a2 = sh[c * 4 + 2];
        a3 = sh[c * 4 + 3];
        if (r < 10) begin
          st[c * 4]     = times_two(a0) ^ times_two(a1) ^ a1 ^ a2 ^ a3;
          st[c * 4 + 1] = a0 ^ times_two(a1) ^ times_two(a2) ^ a2 ^ a3;
          st[c * 4 + 2] = a0 ^ a1 ^ times_two(a2) ^ times_two(a3) ^ a3;
          st[c * 4 + 3] = times_two(a0) ^ a0 ^ a1 ^ a2 ^ times_two(a3);
        end else begin
          st[c * 4] = a0;
          st[c * 4 + 1] = a1;
          st[c * 4 + 2] = a2;
          st[c * 4 + 3] = a3;
        end
      end
      for (int n = 0; n < 16; n++) st[n] ^= rk[r * 16 + n];
    end
    for (int n = 0; n < 16; n++) res[127 - 8 * n -: 8] = st[n];
    return res;
  endfunction

  task automatic report_failure(input string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  // Sender: a presented item stays put until the edge that accepts it.
  always @(negedge clk) begin
    if (rst) begin
      plain_valid <= 1'b0;
    end else if (plain_valid && !plain_fire) begin
      // holding
    end else if (gap_left > 0) begin
      gap_left--;
      plain_valid <= 1'b0;
    end else if (pending_blocks.size() > 0 && gap_odds > 0 &&
                 $urandom_range(0, gap_odds - 1) == 0) begin
      gap_left = $urandom_range(1, 12) - 1;
      plain_valid <= 1'b0;
    end else if (pending_blocks.size() > 0) begin
      plain <= pending_blocks.pop_front();
      plain_valid <= 1'b1;
    end else begin
      plain_valid <= 1'b0;
    end
  end

  // Receiver: ready drops in bursts.
  always @(negedge clk) begin
    if (rst) begin
      cipher_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      cipher_ready <= 1'b0;
    end else if (stall_odds > 0 && $urandom_range(0, stall_odds - 1) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      cipher_ready <= 1'b0;
    end else begin
      cipher_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    aes_pkg::cipher_t want;
    if (rst) begin
      plain_fire <= 1'b0;
    end else begin
      plain_fire <= plain_valid && plain_ready;
      if (cipher_valid && cipher_ready) begin
        if (expected_cipher.size() == 0) begin
          report_failure($sformatf("unexpected cipher item %h_%h",
                                   cipher.cipher_high, cipher.cipher_low));
        end else begin
          want = expected_cipher.pop_front();
          blocks_returned++;
          if (cipher.cipher_high !== want.cipher_high)
            report_failure($sformatf("cipher_high expected %h got %h",
                                     want.cipher_high, cipher.cipher_high));
          if (cipher.cipher_low !== want.cipher_low)
            report_failure($sformatf("cipher_low expected %h got %h",
                                     want.cipher_low, cipher.cipher_low));
        end
      end
      if (plain_valid && plain_ready)
        expected_cipher.push_back(aes_encrypt(key_high_cfg, key_low_cfg, plain));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo);
    aes_pkg::plain_t item;
    item.plain_high = hi;
    item.plain_low = lo;
    pending_blocks.push_back(item);
    blocks_issued++;
  endtask

  task automatic wait_idle();
    while (blocks_returned != blocks_issued) @(negedge clk);
  endtask

  // Key registers change only with the pipe empty.
  task automatic write_key_reg(input logic idx, input logic [63:0] data);
    wait_idle();
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    if (idx == aes_pkg::REG_KEY_HIGH) key_high_cfg = data;
    else key_low_cfg = data;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_random_block();
    logic [127:0] blk;
    int pick;
    blk = {random_word(), random_word()};
    // Now and then a block that is zero but for one byte.
    if ($urandom_range(0, 9) == 0) begin
      pick = $urandom_range(0, 15);
      blk = 128'(blk[7:0]) << (8 * pick);
    end
    queue_block(blk[127:64], blk[63:0]);
  endtask

  initial begin
    aes_pkg::cipher_t kat;
    build_sub_table();
    // Known answer from the standard's example vectors guards the predictor itself.
    kat = aes_encrypt(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                      128'h00112233445566778899aabbccddeeff);
    if (kat !== 128'h69c4e0d86a7b0430d8cdb78070b4c55a)
      report_failure($sformatf("predictor known answer wrong: %h", kat));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Blocks before any key write run under the all-zero reset key.
    gap_odds = 4;
    stall_odds = 4;
    queue_block('0, '0);
    queue_block('1, '1);
    queue_block(64'h0011223344556677, 64'h8899aabbccddeeff);

    write_key_reg(aes_pkg::REG_KEY_HIGH, 64'h0001020304050607);
    write_key_reg(aes_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    queue_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block('0, '1);

    write_key_reg(aes_pkg::REG_KEY_HIGH, 64'h2b7e151628aed2a6);
    write_key_reg(aes_pkg::REG_KEY_LOW, 64'habf7158809cf4f3c);
    queue_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);

    write_key_reg(aes_pkg::REG_KEY_HIGH, '1);
    write_key_reg(aes_pkg::REG_KEY_LOW, '1);
    queue_block('0, '0);
    queue_block('1, '1);
    queue_block(64'h5555555555555555, 64'h5555555555555555);
    queue_block(64'haaaaaaaaaaaaaaaa, 64'haaaaaaaaaaaaaaaa);
    queue_block('1, '0);

    // Only the low half of the key changes here.
    write_key_reg(aes_pkg::REG_KEY_LOW, '0);
    queue_block(64'h8000000000000000, 64'h0000000000000001);
    queue_block(64'h0123456789abcdef, 64'hfedcba9876543210);

    for (int phase = 0; phase < 6; phase++) begin
      write_key_reg(aes_pkg::REG_KEY_HIGH, random_word());
      if (phase != 3) write_key_reg(aes_pkg::REG_KEY_LOW, random_word());
      case (phase % 3)
        0: begin
          gap_odds = 3;
          stall_odds = 3;
        end
        1: begin
          gap_odds = 0;
          stall_odds = 6;
        end
        default: begin
          gap_odds = 8;
          stall_odds = 0;
        end
      endcase
      for (int i = 0; i < 95; i++) queue_random_block();
    end

    // Closing stretch at full rate on both sides.
    write_key_reg(aes_pkg::REG_KEY_HIGH, random_word());
    write_key_reg(aes_pkg::REG_KEY_LOW, random_word());
    gap_odds = 0;
    stall_odds = 0;
    for (int i = 0; i < 80; i++) queue_random_block();

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_cipher.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
src/aes_pkg.sv
src/aes_round_cell.sv
src/aes128_block_encrypt.sv
src/aes_checker.sv
tb/aes128_block_encrypt_test.sv
